// ===== rtl/swaa_pkg.sv =====
`default_nettype none
package swaa_pkg;

  // Sizing
  localparam int QUEUE_DEPTH = 1024;
  localparam int ANTENNAS    = 4;
  localparam int CHANNELS    = 64;
  localparam int SUBBANDS    = 16;

  localparam int QW    = $clog2(QUEUE_DEPTH);
  localparam int QCW   = $clog2(QUEUE_DEPTH + 1);
  localparam int CH_N  = ANTENNAS * CHANNELS;
  localparam int SB_N  = ANTENNAS * SUBBANDS;
  localparam int CI_W  = (CH_N > 1) ? $clog2(CH_N) : 1;
  localparam int SI_W  = (SB_N > 1) ? $clog2(SB_N) : 1;
  localparam int SB_W  = (SUBBANDS > 1) ? $clog2(SUBBANDS) : 1;

  // Field widths
  localparam int MODE_W = 2;
  localparam int NOW_W  = 32;
  localparam int ANT_W  = 2;
  localparam int CHAN_W = 6;
  localparam int SUB_W  = 4;
  localparam int AIR_W  = 24;
  localparam int STAT_W = 2;
  localparam int DUTY_W = 17;
  localparam int WIN_W  = 16;
  localparam int SUM_W  = 64;
  localparam int EXP_W  = NOW_W + 1;
  localparam int DEN_W  = WIN_W + 4;
  localparam int LIM_W  = DEN_W + DUTY_W;

  localparam logic [WIN_W-1:0]  DEFAULT_WINDOW = WIN_W'(3600);
  localparam logic [DUTY_W-1:0] DUTY_MAX       = DUTY_W'(100000);

  // Request modes
  localparam logic [MODE_W-1:0] MODE_REC_UP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REC_DN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EXPIRE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd3;

  // Result status
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNBOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADIDX  = 2'd3;

  typedef struct packed {
    logic [EXP_W-1:0]  expiry;
    logic [AIR_W-1:0]  air;
    logic [ANT_W-1:0]  ant;
    logic [CHAN_W-1:0] chan;
  } qent_t;

  typedef struct packed {
    logic [SB_W-1:0]  sub;
    logic [SUM_W-1:0] up;
    logic [SUM_W-1:0] down;
  } chent_t;

  typedef struct packed {
    logic [SUM_W-1:0] up;
    logic [SUM_W-1:0] down;
  } sbent_t;

endpackage
`default_nettype wire

// ===== rtl/swaa_if.sv =====
`default_nettype none
interface swaa_in_if import swaa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [NOW_W-1:0]  now_s;
  logic [ANT_W-1:0]  antenna;
  logic [CHAN_W-1:0] channel;
  logic [SUB_W-1:0]  subband;
  logic [AIR_W-1:0]  airtime_us;

  modport source (output valid, mode, now_s, antenna, channel, subband, airtime_us,
                  input ready);
  modport sink   (input valid, mode, now_s, antenna, channel, subband, airtime_us,
                  output ready);
endinterface

interface swaa_out_if import swaa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [DUTY_W-1:0] chan_up_duty;
  logic [DUTY_W-1:0] sub_up_duty;
  logic [DUTY_W-1:0] chan_down_duty;
  logic [DUTY_W-1:0] sub_down_duty;

  modport source (output valid, status, chan_up_duty, sub_up_duty, chan_down_duty,
                  sub_down_duty, input ready);
  modport sink   (input valid, status, chan_up_duty, sub_up_duty, chan_down_duty,
                  sub_down_duty, output ready);
endinterface
`default_nettype wire

// ===== rtl/sliding_window_airtime_accounter.sv =====
`default_nettype none
// Sliding-window airtime accounter. Each request runs alone through a small
// sequencer; ready is high only in idle, so the next request is taken once the
// previous result has been loaded into the output register. A query or record
// first decodes and reads the channel and subband tables. It then runs four
// duty divisions on the single shared divider, which finishes early when the
// duty saturates. A bad index goes from decode straight to the output stage.
// An unbound query goes there after the channel table read. An expire handles
// one expired queue entry at a time, downlink queue first, using the one read
// port of the queue, channel and subband memories. A result that is not taken
// holds the sequencer. The channel and subband tables read as zero until first
// written; there is no clearing pass after reset.
module sliding_window_airtime_accounter import swaa_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  swaa_in_if.sink               in_ch,
  swaa_out_if.source            out_ch,
  input  wire logic             cfg_we,
  input  wire logic [WIN_W-1:0] cfg_wdata
);
  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_EXP_CHK, S_EXP_CMP, S_CH_RD, S_CH_USE,
    S_SB_RD, S_SB_USE, S_DIV, S_DIV_WAIT, S_OUT
  } state_t;

  typedef enum logic [1:0] {OP_QRY, OP_REC, OP_EXP} op_t;

  state_t            state_r;
  op_t               op_r;
  logic [WIN_W-1:0]  window_r;
  logic [MODE_W-1:0] mode_r;
  logic [NOW_W-1:0]  now_r;
  logic [ANT_W-1:0]  ant_r;
  logic [CHAN_W-1:0] chan_r;
  logic [SUB_W-1:0]  sub_r;
  logic [AIR_W-1:0]  air_r;
  logic [CI_W-1:0]   ci_r;
  logic [SI_W-1:0]   si_r;
  logic              dir_r;            // 1 downlink, 0 uplink
  logic [STAT_W-1:0] status_r;
  logic [SUM_W-1:0]  cup_r, cdn_r, sup_r, sdn_r;
  logic [DUTY_W-1:0] duty_r [4];
  logic [1:0]        k_r;
  logic [QW-1:0]     head_r [2];
  logic [QCW-1:0]    cnt_r  [2];
  logic              cvalid_r [CH_N];
  logic              svalid_r [SB_N];

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [DUTY_W-1:0] out_duty_r [4];

  // Window and divisor
  logic [WIN_W-1:0] eff_win;
  logic [DEN_W-1:0] den;
  assign eff_win = (window_r == '0) ? WIN_W'(1) : window_r;
  assign den     = (DEN_W'(eff_win) << 3) + (DEN_W'(eff_win) << 1);

  // Memory ports
  qent_t          uq_rdata, dq_rdata, q_ent, q_wdata;
  chent_t         ch_rdata, ch_wdata;
  sbent_t         sb_rdata, sb_wdata;
  logic           uq_we, dq_we, ch_we, sb_we;
  logic [QW-1:0]  q_waddr, q_raddr;
  logic [QW:0]    q_wsum;

  assign q_ent   = dir_r ? dq_rdata : uq_rdata;
  assign q_raddr = head_r[dir_r];
  assign q_wsum  = (QW+1)'(head_r[dir_r]) + (QW+1)'(cnt_r[dir_r]);
  assign q_waddr = (q_wsum >= (QW+1)'(QUEUE_DEPTH)) ?
                   QW'(q_wsum - (QW+1)'(QUEUE_DEPTH)) : q_wsum[QW-1:0];

  // Channel entry as seen (zero when never bound) and its update
  logic              cv, sv;
  chent_t            ch_cur;
  sbent_t            sb_cur;
  logic [SB_W-1:0]   bsub;
  logic [SUM_W-1:0]  c_old, c_new, s_old, s_new;
  logic [SUM_W:0]    c_add, s_add;

  assign cv     = cvalid_r[ci_r];
  assign sv     = svalid_r[si_r];
  assign ch_cur = cv ? ch_rdata : '0;
  assign sb_cur = sv ? sb_rdata : '0;
  assign bsub   = cv ? ch_rdata.sub : SB_W'(sub_r);

  assign c_old = dir_r ? ch_cur.down : ch_cur.up;
  assign s_old = dir_r ? sb_cur.down : sb_cur.up;
  assign c_add = (SUM_W+1)'(c_old) + (SUM_W+1)'(air_r);
  assign s_add = (SUM_W+1)'(s_old) + (SUM_W+1)'(air_r);

  // Saturating add on record, floored subtract on expiry
  always_comb begin
    if (op_r == OP_EXP) begin
      c_new = (c_old > SUM_W'(air_r)) ? c_old - SUM_W'(air_r) : '0;
      s_new = (s_old > SUM_W'(air_r)) ? s_old - SUM_W'(air_r) : '0;
    end else begin
      c_new = c_add[SUM_W] ? '1 : c_add[SUM_W-1:0];
      s_new = s_add[SUM_W] ? '1 : s_add[SUM_W-1:0];
    end
  end

  always_comb begin
    ch_wdata      = ch_cur;
    ch_wdata.sub  = bsub;
    if (dir_r) ch_wdata.down = c_new;
    else       ch_wdata.up   = c_new;
    sb_wdata      = sb_cur;
    if (dir_r) sb_wdata.down = s_new;
    else       sb_wdata.up   = s_new;
  end

  assign q_wdata.expiry = EXP_W'(now_r) + EXP_W'(eff_win);
  assign q_wdata.air    = air_r;
  assign q_wdata.ant    = ant_r;
  assign q_wdata.chan   = chan_r;

  assign ch_we = (state_r == S_CH_USE) && (op_r != OP_QRY);
  assign sb_we = (state_r == S_SB_USE) && (op_r != OP_QRY);
  assign uq_we = (state_r == S_CH_USE) && (op_r == OP_REC) && !dir_r;
  assign dq_we = (state_r == S_CH_USE) && (op_r == OP_REC) && dir_r;

  swaa_ram #(.WIDTH($bits(qent_t)), .DEPTH(QUEUE_DEPTH)) u_upq (
    .clk(clk), .we(uq_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(uq_rdata)
  );
  swaa_ram #(.WIDTH($bits(qent_t)), .DEPTH(QUEUE_DEPTH)) u_dnq (
    .clk(clk), .we(dq_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(dq_rdata)
  );
  swaa_ram #(.WIDTH($bits(chent_t)), .DEPTH(CH_N)) u_chan (
    .clk(clk), .we(ch_we), .waddr(ci_r), .wdata(ch_wdata),
    .raddr(ci_r), .rdata(ch_rdata)
  );
  swaa_ram #(.WIDTH($bits(sbent_t)), .DEPTH(SB_N)) u_sub (
    .clk(clk), .we(sb_we), .waddr(si_r), .wdata(sb_wdata),
    .raddr(si_r), .rdata(sb_rdata)
  );

  // Shared duty divider
  logic              div_start, div_done;
  logic [SUM_W-1:0]  div_sum;
  logic [DUTY_W-1:0] div_quo;

  assign div_start = (state_r == S_DIV);
  always_comb begin
    case (k_r)
      2'd0:    div_sum = cup_r;
      2'd1:    div_sum = sup_r;
      2'd2:    div_sum = cdn_r;
      default: div_sum = sdn_r;
    endcase
  end

  swaa_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .sum(div_sum), .den(den),
    .done(div_done), .quo(div_quo)
  );

  // Decode helpers
  logic          bad_idx;
  logic [CI_W-1:0] ci_in;
  assign bad_idx = (32'(ant_r) >= ANTENNAS) || (32'(chan_r) >= CHANNELS) ||
                   (((mode_r == MODE_REC_UP) || (mode_r == MODE_REC_DN)) &&
                    (32'(sub_r) >= SUBBANDS));
  assign ci_in   = CI_W'(32'(ant_r) * CHANNELS + 32'(chan_r));

  // Handshake
  logic out_fire;
  assign out_fire              = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.chan_up_duty   = out_duty_r[0];
  assign out_ch.sub_up_duty    = out_duty_r[1];
  assign out_ch.chan_down_duty = out_duty_r[2];
  assign out_ch.sub_down_duty  = out_duty_r[3];

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_QRY;
      window_r    <= DEFAULT_WINDOW;
      out_valid_r <= 1'b0;
      dir_r       <= 1'b0;
      k_r         <= '0;
      for (int i = 0; i < 2; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      for (int i = 0; i < CH_N; i++) cvalid_r[i] <= 1'b0;
      for (int i = 0; i < SB_N; i++) svalid_r[i] <= 1'b0;
    end else begin
      if (cfg_we) window_r <= cfg_wdata;
      if (out_fire) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            mode_r  <= in_ch.mode;
            now_r   <= in_ch.now_s;
            ant_r   <= in_ch.antenna;
            chan_r  <= in_ch.channel;
            sub_r   <= in_ch.subband;
            air_r   <= in_ch.airtime_us;
            state_r <= S_DEC;
          end
        end
        S_DEC: begin
          for (int i = 0; i < 4; i++) duty_r[i] <= '0;
          ci_r <= ci_in;
          k_r  <= '0;
          if (mode_r == MODE_EXPIRE) begin
            status_r <= ST_OK;
            op_r     <= OP_EXP;
            dir_r    <= 1'b1;
            state_r  <= S_EXP_CHK;
          end else if (bad_idx) begin
            status_r <= ST_BADIDX;
            state_r  <= S_OUT;
          end else if (mode_r == MODE_QUERY) begin
            status_r <= ST_OK;
            op_r     <= OP_QRY;
            state_r  <= S_CH_RD;
          end else begin
            dir_r   <= mode_r[0];
            state_r <= S_CH_RD;
            if (cnt_r[mode_r[0]] >= QCW'(QUEUE_DEPTH)) begin
              op_r     <= OP_QRY;
              status_r <= ST_FULL;
            end else begin
              op_r     <= OP_REC;
              status_r <= ST_OK;
            end
          end
        end
        // queue head is read while here when the queue holds entries
        S_EXP_CHK: begin
          if (cnt_r[dir_r] == '0) begin
            if (dir_r) dir_r <= 1'b0;
            else       state_r <= S_OUT;
          end else begin
            state_r <= S_EXP_CMP;
          end
        end
        S_EXP_CMP: begin
          if (q_ent.expiry < EXP_W'(now_r)) begin
            ant_r   <= q_ent.ant;
            chan_r  <= q_ent.chan;
            air_r   <= q_ent.air;
            ci_r    <= CI_W'(32'(q_ent.ant) * CHANNELS + 32'(q_ent.chan));
            state_r <= S_CH_RD;
          end else if (dir_r) begin
            dir_r   <= 1'b0;
            state_r <= S_EXP_CHK;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_CH_RD: state_r <= S_CH_USE;
        S_CH_USE: begin
          si_r  <= SI_W'(32'(ant_r) * SUBBANDS + 32'(bsub));
          if (op_r == OP_QRY) begin
            cup_r <= ch_cur.up;
            cdn_r <= ch_cur.down;
            if (!cv) begin
              if (status_r == ST_OK) status_r <= ST_UNBOUND;
              state_r <= S_OUT;
            end else begin
              state_r <= S_SB_RD;
            end
          end else begin
            cup_r        <= ch_wdata.up;
            cdn_r        <= ch_wdata.down;
            cvalid_r[ci_r] <= 1'b1;
            if (op_r == OP_REC) cnt_r[dir_r] <= cnt_r[dir_r] + QCW'(1);
            state_r <= S_SB_RD;
          end
        end
        S_SB_RD: state_r <= S_SB_USE;
        S_SB_USE: begin
          sup_r <= (op_r == OP_QRY) ? sb_cur.up : sb_wdata.up;
          sdn_r <= (op_r == OP_QRY) ? sb_cur.down : sb_wdata.down;
          if (op_r != OP_QRY) svalid_r[si_r] <= 1'b1;
          if (op_r == OP_EXP) begin
            head_r[dir_r] <= (head_r[dir_r] == QW'(QUEUE_DEPTH - 1)) ?
                             '0 : head_r[dir_r] + QW'(1);
            cnt_r[dir_r]  <= cnt_r[dir_r] - QCW'(1);
            state_r       <= S_EXP_CHK;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            duty_r[k_r] <= div_quo;
            k_r         <= k_r + 2'd1;
            state_r     <= (k_r == 2'd3) ? S_OUT : S_DIV;
          end
        end
        S_OUT: begin
          if (out_fire) begin
            out_status_r <= status_r;
            for (int i = 0; i < 4; i++) out_duty_r[i] <= duty_r[i];
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/swaa_ram.sv =====
`default_nettype none
module swaa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/swaa_div.sv =====
`default_nettype none
// Duty divider: quo = min(sum / den, DUTY_MAX), restoring, one quotient bit a cycle
module swaa_div import swaa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SUM_W-1:0]  sum,
  input  wire logic [DEN_W-1:0]  den,
  output logic                   done,
  output logic      [DUTY_W-1:0] quo
);
  localparam int BIT_W = $clog2(DUTY_W);

  typedef enum logic [1:0] {D_IDLE, D_LIM, D_CHK, D_RUN} dstate_t;

  dstate_t           state_r;
  logic [SUM_W-1:0]  num_r;
  logic [DEN_W-1:0]  den_r;
  logic [LIM_W-1:0]  lim_r;
  logic [LIM_W-1:0]  rem_r;
  logic [LIM_W-1:0]  dsh_r;
  logic [BIT_W-1:0]  bit_r;
  logic [DUTY_W-1:0] quo_r;
  logic              done_r;

  assign done = done_r;
  assign quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            num_r   <= sum;
            den_r   <= den;
            state_r <= D_LIM;
          end
        end
        // smallest sum that would exceed the duty ceiling
        D_LIM: begin
          lim_r   <= LIM_W'(den_r) * LIM_W'(DUTY_MAX + DUTY_W'(1));
          state_r <= D_CHK;
        end
        D_CHK: begin
          if (num_r >= SUM_W'(lim_r)) begin
            quo_r   <= DUTY_MAX;
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end else begin
            rem_r   <= num_r[LIM_W-1:0];
            dsh_r   <= LIM_W'(den_r) << (DUTY_W - 1);
            bit_r   <= BIT_W'(DUTY_W - 1);
            quo_r   <= '0;
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          if (rem_r >= dsh_r) begin
            rem_r        <= rem_r - dsh_r;
            quo_r[bit_r] <= 1'b1;
          end
          dsh_r <= dsh_r >> 1;
          bit_r <= bit_r - BIT_W'(1);
          if (bit_r == '0) begin
            done_r  <= 1'b1;
            state_r <= D_IDLE;
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== bench/sliding_window_airtime_accounter_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_airtime_accounter_tb;
  import swaa_pkg::*;

  localparam int STALL_LIMIT = 100000;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [NOW_W-1:0]  now_s;
    logic [ANT_W-1:0]  antenna;
    logic [CHAN_W-1:0] channel;
    logic [SUB_W-1:0]  subband;
    logic [AIR_W-1:0]  airtime_us;
  } airtime_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DUTY_W-1:0] chan_up;
    logic [DUTY_W-1:0] sub_up;
    logic [DUTY_W-1:0] chan_down;
    logic [DUTY_W-1:0] sub_down;
  } duty_report_t;

  // Shadow of the accounter: expiry queues, sums, bindings, window
  class airtime_scoreboard;
    qent_t              up_fifo[$];
    qent_t              down_fifo[$];
    bit [SUM_W-1:0]     chan_up_sum[CH_N];
    bit [SUM_W-1:0]     chan_down_sum[CH_N];
    bit                 bound[CH_N];
    bit [SB_W-1:0]      bound_sub[CH_N];
    bit [SUM_W-1:0]     sub_up_sum[SB_N];
    bit [SUM_W-1:0]     sub_down_sum[SB_N];
    bit [WIN_W-1:0]     window_s;
    duty_report_t       pending_reports[$];
    int                 fails, n_rec, n_exp, n_query, n_full, n_unbound;

    function new();
      window_s = DEFAULT_WINDOW;
      foreach (bound[i]) begin
        bound[i] = 0; bound_sub[i] = '0; chan_up_sum[i] = '0; chan_down_sum[i] = '0;
      end
      foreach (sub_up_sum[i]) begin
        sub_up_sum[i] = '0; sub_down_sum[i] = '0;
      end
    endfunction

    function bit [SUM_W-1:0] sat_add(bit [SUM_W-1:0] a, bit [SUM_W-1:0] b);
      bit [SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function bit [SUM_W-1:0] floor_sub(bit [SUM_W-1:0] a, bit [SUM_W-1:0] b);
      return (a > b) ? a - b : '0;
    endfunction

    function bit [DUTY_W-1:0] duty_of(bit [SUM_W-1:0] s);
      bit [SUM_W-1:0] den, q;
      den = ((window_s == 0) ? 64'd1 : 64'(window_s)) * 64'd10;
      q = s / den;
      return (q > 64'(DUTY_MAX)) ? DUTY_MAX : q[DUTY_W-1:0];
    endfunction

    function duty_report_t report_of(int ci, int ant);
      duty_report_t r;
      int si;
      si = ant * SUBBANDS + bound_sub[ci];
      r.status    = ST_OK;
      r.chan_up   = duty_of(chan_up_sum[ci]);
      r.sub_up    = duty_of(sub_up_sum[si]);
      r.chan_down = duty_of(chan_down_sum[ci]);
      r.sub_down  = duty_of(sub_down_sum[si]);
      return r;
    endfunction

    function void book(bit down, int ant, int chan, bit [AIR_W-1:0] air, bit add);
      int ci, si;
      bit [SUM_W-1:0] a;
      ci = ant * CHANNELS + chan;
      si = ant * SUBBANDS + bound_sub[ci];
      a = SUM_W'(air);
      if (down) begin
        chan_down_sum[ci] = add ? sat_add(chan_down_sum[ci], a) :
                                  floor_sub(chan_down_sum[ci], a);
        sub_down_sum[si]  = add ? sat_add(sub_down_sum[si], a) :
                                  floor_sub(sub_down_sum[si], a);
      end else begin
        chan_up_sum[ci] = add ? sat_add(chan_up_sum[ci], a) :
                                floor_sub(chan_up_sum[ci], a);
        sub_up_sum[si]  = add ? sat_add(sub_up_sum[si], a) :
                                floor_sub(sub_up_sum[si], a);
      end
    endfunction

    // Accepted request: update shadow state, queue the expected report
    function void note_request(airtime_req_t rq);
      duty_report_t r;
      qent_t e;
      int ci;
      bit down;
      r = '0;
      if (rq.mode == MODE_EXPIRE) begin
        n_exp++;
        while (down_fifo.size() > 0 && down_fifo[0].expiry < EXP_W'(rq.now_s)) begin
          e = down_fifo.pop_front();
          book(1, e.ant, e.chan, e.air, 0);
        end
        while (up_fifo.size() > 0 && up_fifo[0].expiry < EXP_W'(rq.now_s)) begin
          e = up_fifo.pop_front();
          book(0, e.ant, e.chan, e.air, 0);
        end
      end else if (rq.antenna >= ANTENNAS || rq.channel >= CHANNELS ||
                   (rq.mode != MODE_QUERY && rq.subband >= SUBBANDS)) begin
        r.status = ST_BADIDX;
      end else begin
        ci = rq.antenna * CHANNELS + rq.channel;
        down = (rq.mode == MODE_REC_DN);
        if (rq.mode == MODE_QUERY) begin
          n_query++;
          if (!bound[ci]) begin
            r.status = ST_UNBOUND;
            n_unbound++;
          end else r = report_of(ci, rq.antenna);
        end else if ((down ? down_fifo.size() : up_fifo.size()) >= QUEUE_DEPTH) begin
          n_full++;
          if (bound[ci]) r = report_of(ci, rq.antenna);
          r.status = ST_FULL;
        end else begin
          n_rec++;
          if (!bound[ci]) begin
            bound[ci] = 1;
            bound_sub[ci] = rq.subband;
          end
          e.expiry = EXP_W'(rq.now_s) + EXP_W'((window_s == 0) ? 1 : window_s);
          e.air = rq.airtime_us;
          e.ant = rq.antenna;
          e.chan = rq.channel;
          if (down) down_fifo.push_back(e);
          else up_fifo.push_back(e);
          book(down, rq.antenna, rq.channel, rq.airtime_us, 1);
          r = report_of(ci, rq.antenna);
        end
      end
      pending_reports.push_back(r);
    endfunction

    function void check_result(duty_report_t act);
      duty_report_t exp_r;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report %h", $time, act);
        fails++;
        return;
      end
      exp_r = pending_reports.pop_front();
      if (act.status !== exp_r.status) begin
        $display("%0t: status exp %0d got %0d", $time, exp_r.status, act.status);
        fails++;
      end
      if (act.chan_up !== exp_r.chan_up) begin
        $display("%0t: chan_up_duty exp %0d got %0d", $time, exp_r.chan_up, act.chan_up);
        fails++;
      end
      if (act.sub_up !== exp_r.sub_up) begin
        $display("%0t: sub_up_duty exp %0d got %0d", $time, exp_r.sub_up, act.sub_up);
        fails++;
      end
      if (act.chan_down !== exp_r.chan_down) begin
        $display("%0t: chan_down_duty exp %0d got %0d", $time, exp_r.chan_down,
                 act.chan_down);
        fails++;
      end
      if (act.sub_down !== exp_r.sub_down) begin
        $display("%0t: sub_down_duty exp %0d got %0d", $time, exp_r.sub_down, act.sub_down);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [WIN_W-1:0] cfg_wdata;
  swaa_in_if  in_ch();
  swaa_out_if out_ch();

  airtime_scoreboard sb = new();
  bit   calm;
  bit   held_off;
  int   n_reports;
  int   idle_cycles;
  logic [NOW_W-1:0] clock_s;

  sliding_window_airtime_accounter u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, occasionally a long one; none while calm
  function int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one request; returns at the falling edge after acceptance, or after a random gap
  task send_req(input airtime_req_t rq);
    int gap;
    in_ch.mode = rq.mode;
    in_ch.now_s = rq.now_s;
    in_ch.antenna = rq.antenna;
    in_ch.channel = rq.channel;
    in_ch.subband = rq.subband;
    in_ch.airtime_us = rq.airtime_us;
    in_ch.valid = 1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(rq);
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task send(input logic [MODE_W-1:0] m, input logic [NOW_W-1:0] t, input int ant,
            input int chan, input int sub, input logic [AIR_W-1:0] air);
    airtime_req_t rq;
    rq.mode = m; rq.now_s = t; rq.antenna = ANT_W'(ant); rq.channel = CHAN_W'(chan);
    rq.subband = SUB_W'(sub); rq.airtime_us = air;
    send_req(rq);
  endtask

  // Window change only once everything is drained
  task set_window(input logic [WIN_W-1:0] w);
    in_ch.valid = 0;
    while (sb.pending_reports.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we = 1;
    cfg_wdata = w;
    @(negedge clk);
    cfg_we = 0;
    sb.window_s = w;
  endtask

  task random_phase(input int n);
    airtime_req_t rq;
    int p;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      clock_s += $urandom_range(0, 4);
      p = $urandom_range(0, 99);
      rq.mode = (p < 35) ? MODE_REC_UP : (p < 65) ? MODE_REC_DN :
                (p < 80) ? MODE_EXPIRE : MODE_QUERY;
      rq.now_s = ($urandom_range(0, 49) == 0) ? NOW_W'($urandom) : clock_s;
      rq.antenna = ANT_W'($urandom_range(0, 3));
      rq.channel = CHAN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) :
                                                        $urandom_range(0, 5));
      rq.subband = SUB_W'($urandom_range(0, 15));
      rq.airtime_us = ($urandom_range(0, 2) == 0) ? AIR_W'($urandom) :
                      AIR_W'($urandom_range(0, 200000));
      send_req(rq);
    end
  endtask

  // Result side: random stalls plus one long hold-off
  initial begin
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result({out_ch.status, out_ch.chan_up_duty, out_ch.sub_up_duty,
                         out_ch.chan_down_duty, out_ch.sub_down_duty});
        n_reports++;
      end
      @(negedge clk);
      if (!held_off && n_reports >= 150) begin
        held_off = 1;
        out_ch.ready = 0;
        repeat (400) @(negedge clk);
      end else if (!calm && $urandom_range(0, 99) < 3) begin
        out_ch.ready = 0;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end else begin
        out_ch.ready = calm || ($urandom_range(0, 99) < 70);
      end
    end
  end

  // Watchdog: cycles with no handshake on either side
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    in_ch.valid = 0;
    in_ch.mode = '0;
    in_ch.now_s = '0;
    in_ch.antenna = '0;
    in_ch.channel = '0;
    in_ch.subband = '0;
    in_ch.airtime_us = '0;
    calm = 0;
    held_off = 0;
    n_reports = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed: unbound query, extremes, rebinding ignored, expiry edges
    send(MODE_QUERY, 0, 0, 0, 0, 0);
    send(MODE_REC_UP, 0, 0, 0, 0, '1);
    send(MODE_REC_DN, 0, 0, 0, 15, '1);
    send(MODE_REC_UP, 5, 0, 0, 9, 12345);
    send(MODE_REC_UP, '1, 3, 63, 15, 0);
    send(MODE_REC_DN, 100, 3, 63, 3, 777777);
    send(MODE_QUERY, 200, 0, 0, 15, '1);
    send(MODE_QUERY, 200, 3, 63, 0, 0);
    send(MODE_EXPIRE, 3600, 2, 17, 5, 99);
    send(MODE_QUERY, 300, 0, 0, 0, 0);
    send(MODE_EXPIRE, 3606, 0, 0, 0, 0);
    send(MODE_QUERY, 300, 0, 0, 0, 0);
    send(MODE_EXPIRE, '1, 0, 0, 0, 0);
    send(MODE_QUERY, 300, 3, 63, 0, 0);

    // Tiny windows saturate the duty; zero behaves as one
    set_window(1);
    send(MODE_REC_UP, 10, 1, 7, 2, '1);
    send(MODE_REC_DN, 10, 1, 8, 2, 999999);
    send(MODE_QUERY, 10, 1, 8, 0, 0);
    set_window(0);
    send(MODE_REC_UP, 11, 1, 7, 0, 500000);
    send(MODE_EXPIRE, 12, 0, 0, 0, 0);
    send(MODE_QUERY, 12, 1, 7, 0, 0);
    send(MODE_EXPIRE, 13, 0, 0, 0, 0);
    send(MODE_QUERY, 13, 1, 8, 0, 0);

    // Longest window, a burst on both queues, then drain with one expire
    set_window('1);
    for (int i = 0; i < 24; i++)
      send((i % 2) ? MODE_REC_DN : MODE_REC_UP, 1000, i % 4, (i / 4) % 64,
           $urandom_range(0, 15), AIR_W'($urandom));
    send(MODE_QUERY, 1000, 2, 5, 0, 0);
    send(MODE_EXPIRE, '1, 0, 0, 0, 0);
    send(MODE_QUERY, 1000, 2, 5, 0, 0);

    // Random traffic over several windows
    clock_s = 2000;
    set_window(WIN_W'($urandom_range(1, 30)));
    random_phase(160);
    set_window(WIN_W'($urandom_range(2, 12)));
    random_phase(160);
    set_window(3600);
    random_phase(140);
    set_window(16'($urandom_range(1, 65535)));
    random_phase(130);
    calm = 0;

    in_ch.valid = 0;
    while (sb.pending_reports.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("Covered %0d records, %0d full drops, %0d expires, %0d queries (%0d unbound),",
             sb.n_rec, sb.n_full, sb.n_exp, sb.n_query, sb.n_unbound);
    $display("windows 0, 1, max and random, with a long result-side hold-off.");
    if (sb.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
